// ===== src/tree_ancestor_query_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the tree ancestor query engine checker.
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TREE_ANCESTOR_QUERY_ENGINE_MACROS_SVH
`define TREE_ANCESTOR_QUERY_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define TAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define TAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/taq_pkg.sv =====
// ----------------------------------------------------------------------------
// taq_pkg
// Shared field widths, action and status codes, controller states and the
// command / status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package taq_pkg;

  // Field widths of the item channels
  localparam int ACTION_W     = 2;
  localparam int NODE_FIELD_W = 10;
  localparam int TOTAL_W      = 11;
  localparam int STATUS_W     = 2;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_BEGIN  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_IGNORE = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MALFORMED = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_WR,
    ST_WALK_INIT,
    ST_WALK_DEC,
    ST_WALK_POP,
    ST_WALK_END,
    ST_QRY_OUT
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // input transfer this cycle
    logic clr_step;   // clear one list head and one seen flag
    logic add_wr;     // link child under parent (or flag fault)
    logic walk_init;  // stamp and push the root
    logic push;       // descend into current node
    logic pop_rd;     // pop: read top of stack
    logic pop_fin;    // pop: stamp exit, fetch next sibling
    logic walk_end;   // close walk, check visit count
    logic qry_rd;     // re-read stamps for the held query
    logic qry_out;    // load the result register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clr_last;
    logic need_walk;
    logic push_ok;
    logic sp_zero;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/taq_ctrl.sv =====
// ----------------------------------------------------------------------------
// taq_ctrl
// Sequencer for the ancestor query engine: clear sweep, link insertion,
// depth-first walk steps and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module taq_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [taq_pkg::ACTION_W-1:0]    in_action,
  output logic                            in_stall,
  input  taq_pkg::dp_stat_t               stat,
  output taq_pkg::dp_cmd_t                cmd
);
  import taq_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        accept;

  // State register; reset starts with a clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.load  = accept;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (in_action)
            ACT_BEGIN:  state_nxt = ST_CLEAR;
            ACT_ADD:    state_nxt = ST_ADD_WR;
            ACT_QUERY:  state_nxt = stat.need_walk ? ST_WALK_INIT : ST_QRY_OUT;
            ACT_IGNORE: state_nxt = ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_WALK_INIT: begin
        cmd.walk_init = 1'b1;
        state_nxt     = ST_WALK_DEC;
      end
      ST_WALK_DEC: begin
        if (stat.push_ok) begin
          cmd.push = 1'b1;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = ST_WALK_POP;
        end
      end
      ST_WALK_POP: begin
        cmd.pop_fin = 1'b1;
        state_nxt   = stat.sp_zero ? ST_WALK_END : ST_WALK_DEC;
      end
      ST_WALK_END: begin
        cmd.walk_end = 1'b1;
        cmd.qry_rd   = 1'b1;
        state_nxt    = ST_QRY_OUT;
      end
      ST_QRY_OUT: begin
        if (stat.out_free) begin
          cmd.qry_out = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/taq_datapath.sv =====
// ----------------------------------------------------------------------------
// taq_datapath
// Tree storage (list heads, sibling links, seen flags), walk stack, entry and
// exit stamp memories, walk counters and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module taq_datapath #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  taq_pkg::dp_cmd_t                    cmd,
  output taq_pkg::dp_stat_t                   stat,
  input  logic [taq_pkg::ACTION_W-1:0]        in_action,
  input  logic [taq_pkg::NODE_FIELD_W-1:0]    in_first_node,
  input  logic [taq_pkg::NODE_FIELD_W-1:0]    in_second_node,
  input  logic [taq_pkg::TOTAL_W-1:0]         in_node_total,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_ancestor,
  output logic [taq_pkg::STATUS_W-1:0]        out_status
);
  import taq_pkg::*;

  localparam int NW = $clog2(MAX_NODES);          // node index
  localparam int LW = $clog2(MAX_NODES + 1);      // node count / stack depth
  localparam int SW = $clog2(2 * MAX_NODES);      // stamp
  localparam int PW = NW + 1;                     // node pointer, MSB = none
  localparam int CW = (LW > NODE_FIELD_W) ? LW : NODE_FIELD_W;
  localparam int TW = (LW > TOTAL_W) ? LW : TOTAL_W;
  localparam logic [PW-1:0] PTR_NONE = {1'b1, {NW{1'b0}}};

  // Memories
  logic [PW-1:0] fc_mem    [MAX_NODES];   // first child of each node
  logic [PW:0]   link_mem  [MAX_NODES];   // {seen, next sibling} per child
  logic [SW-1:0] entry_mem [MAX_NODES];
  logic [SW-1:0] exit_mem  [MAX_NODES];
  logic [NW-1:0] stack_mem [MAX_NODES];

  // Control registers
  logic [LW-1:0] node_limit_r;
  logic          faulty_r;
  logic          stamps_valid_r;
  logic [NW-1:0] clr_idx_r;
  logic          out_valid_r;

  // Held item and walk registers
  logic [NODE_FIELD_W-1:0] a_r, b_r;
  logic [LW-1:0]           sp_r;
  logic [SW-1:0]           stamp_r;
  logic [LW-1:0]           visited_r;
  logic                    cur_link_r;

  // Registered read data
  logic [PW-1:0] fc_rd_r;
  logic [PW:0]   link_rd_r;
  logic [NW-1:0] stack_rd_r;
  logic [SW-1:0] entry_a_rd_r, entry_b_rd_r, exit_a_rd_r;

  // Result register
  logic                out_anc_r;
  logic [STATUS_W-1:0] out_status_r;

  // Combinational
  logic                is_begin;
  logic [TW-1:0]       total_ext;
  logic [LW-1:0]       limit_nxt;
  logic                a_range_bad, b_range_bad;
  logic                add_bad, add_ok;
  logic [PW-1:0]       cur_ptr;
  logic [NW-1:0]       cur_node;
  logic [LW-1:0]       sp_dec;
  logic [NW-1:0]       fc_raddr, link_raddr, entry_a_addr, entry_b_addr;
  logic [STATUS_W-1:0] q_status;
  logic                q_anc;
  logic                out_free;

  assign is_begin  = cmd.load && (in_action == ACT_BEGIN);

  // Node count for begin: zero counts as one, saturate at capacity
  assign total_ext = TW'(in_node_total);
  always_comb begin
    if (in_node_total == '0) begin
      limit_nxt = LW'(1);
    end else if (total_ext > TW'(MAX_NODES)) begin
      limit_nxt = LW'(MAX_NODES);
    end else begin
      limit_nxt = LW'(total_ext);
    end
  end

  // Range checks on the held item
  assign a_range_bad = CW'(a_r) >= CW'(node_limit_r);
  assign b_range_bad = CW'(b_r) >= CW'(node_limit_r);
  assign add_bad     = (a_r == '0) || a_range_bad || b_range_bad || link_rd_r[PW];
  assign add_ok      = cmd.add_wr && !add_bad;

  // Current walk pointer comes from a list head or a sibling link
  assign cur_ptr  = cur_link_r ? link_rd_r[PW-1:0] : fc_rd_r;
  assign cur_node = cur_ptr[NW-1:0];
  assign sp_dec   = sp_r - LW'(1);

  // Read addresses
  assign fc_raddr     = cmd.load ? NW'(in_second_node) :
                        (cmd.walk_init ? '0 : cur_node);
  assign link_raddr   = cmd.load ? NW'(in_first_node) : stack_rd_r;
  assign entry_a_addr = cmd.load ? NW'(in_first_node) : NW'(a_r);
  assign entry_b_addr = cmd.load ? NW'(in_second_node) : NW'(b_r);

  // First-child memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      fc_mem[clr_idx_r] <= PTR_NONE;
    end else if (add_ok) begin
      fc_mem[NW'(b_r)] <= {1'b0, NW'(a_r)};
    end
    if (cmd.load || cmd.walk_init || cmd.push) begin
      fc_rd_r <= fc_mem[fc_raddr];
    end
  end

  // Seen flag and next-sibling memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      link_mem[clr_idx_r] <= {1'b0, PTR_NONE};
    end else if (add_ok) begin
      link_mem[NW'(a_r)] <= {1'b1, fc_rd_r};
    end
    if (cmd.load || cmd.pop_fin) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  // Walk stack
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      stack_mem[0] <= '0;
    end else if (cmd.push) begin
      stack_mem[NW'(sp_r)] <= cur_node;
    end
    if (cmd.pop_rd) begin
      stack_rd_r <= stack_mem[NW'(sp_dec)];
    end
  end

  // Entry stamps, two read ports for the query
  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      entry_mem[0] <= '0;
    end else if (cmd.push) begin
      entry_mem[cur_node] <= stamp_r;
    end
    if (cmd.load || cmd.qry_rd) begin
      entry_a_rd_r <= entry_mem[entry_a_addr];
      entry_b_rd_r <= entry_mem[entry_b_addr];
    end
  end

  // Exit stamps
  always_ff @(posedge clk) begin
    if (cmd.pop_fin) begin
      exit_mem[stack_rd_r] <= stamp_r;
    end
    if (cmd.load || cmd.qry_rd) begin
      exit_a_rd_r <= exit_mem[entry_a_addr];
    end
  end

  // Tree-level control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_limit_r   <= LW'(1);
      faulty_r       <= 1'b0;
      stamps_valid_r <= 1'b0;
      clr_idx_r      <= '0;
    end else begin
      if (is_begin) begin
        node_limit_r   <= limit_nxt;
        faulty_r       <= 1'b0;
        stamps_valid_r <= 1'b0;
        clr_idx_r      <= '0;
      end
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + NW'(1);
      end
      if (cmd.add_wr) begin
        if (add_bad) begin
          faulty_r <= 1'b1;
        end else begin
          stamps_valid_r <= 1'b0;
        end
      end
      if (cmd.walk_end) begin
        stamps_valid_r <= 1'b1;
        if (visited_r != node_limit_r) faulty_r <= 1'b1;
      end
    end
  end

  // Held item and walk counters
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= in_first_node;
      b_r <= in_second_node;
    end
    if (cmd.walk_init) begin
      sp_r       <= LW'(1);
      stamp_r    <= SW'(1);
      visited_r  <= LW'(1);
      cur_link_r <= 1'b0;
    end else if (cmd.push) begin
      sp_r       <= sp_r + LW'(1);
      stamp_r    <= stamp_r + SW'(1);
      visited_r  <= visited_r + LW'(1);
      cur_link_r <= 1'b0;
    end else if (cmd.pop_rd) begin
      sp_r <= sp_dec;
    end else if (cmd.pop_fin) begin
      stamp_r    <= stamp_r + SW'(1);
      cur_link_r <= 1'b1;
    end
  end

  // Query answer from the stamps
  always_comb begin
    if (a_range_bad || b_range_bad) begin
      q_status = STATUS_RANGE;
    end else if (faulty_r) begin
      q_status = STATUS_MALFORMED;
    end else begin
      q_status = STATUS_OK;
    end
    q_anc = (q_status == STATUS_OK) && (entry_a_rd_r <= entry_b_rd_r) &&
            (entry_b_rd_r <= exit_a_rd_r);
  end

  // Result register: refilled when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.qry_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.qry_out) begin
      out_anc_r    <= q_anc;
      out_status_r <= q_status;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_ancestor = out_anc_r;
  assign out_status      = out_status_r;

  // Status to the controller
  assign stat.clr_last  = (clr_idx_r == NW'(MAX_NODES - 1));
  assign stat.need_walk = !stamps_valid_r && !faulty_r;
  assign stat.push_ok   = !cur_ptr[NW] && (LW'(cur_node) < node_limit_r) &&
                          (sp_r < LW'(MAX_NODES));
  assign stat.sp_zero   = (sp_r == '0);
  assign stat.out_free  = out_free;

endmodule

`default_nettype wire

// ===== src/tree_ancestor_query_engine.sv =====
// ----------------------------------------------------------------------------
// Tree ancestor query engine
// Input items: begin (fix node count, empty the tree), add (link child under
//   parent), query (is first_node an ancestor of or equal to second_node).
//   Only queries produce a result (is_ancestor, status).
// Both channels use valid/stall; a transfer happens when valid is high and
//   stall is low. One item is worked on at a time.
// Items: an ignored action needs nothing beyond its transfer; an add writes
//   its link in an add state; a query with current stamps goes to the output
//   state, which loads its result once the result register is free. The first
//   query after a tree change also runs the depth-first walk: init, a push per
//   reachable node, a read and a finish per pop via the stack memory, and end.
// Begin and reset: a clearing pass over the MAX_NODES list-head and seen-flag
//   entries, with the input stalled; after reset the tree is the root alone
//   until the first begin.
// Output: a result register; while the receiver stalls, adds and begins keep
//   being taken, and a following query waits with its answer until the
//   register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_engine #(
  parameter int MAX_NODES = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [taq_pkg::ACTION_W-1:0]        in_action,
  input  logic [taq_pkg::NODE_FIELD_W-1:0]    in_first_node,
  input  logic [taq_pkg::NODE_FIELD_W-1:0]    in_second_node,
  input  logic [taq_pkg::TOTAL_W-1:0]         in_node_total,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_is_ancestor,
  output logic [taq_pkg::STATUS_W-1:0]        out_status
);
  import taq_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  taq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Storage and arithmetic
  taq_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (in_action),
    .in_first_node   (in_first_node),
    .in_second_node  (in_second_node),
    .in_node_total   (in_node_total),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_is_ancestor (out_is_ancestor),
    .out_status      (out_status)
  );

endmodule

`default_nettype wire

// ===== src/taq_checker.sv =====
// ----------------------------------------------------------------------------
// taq_checker
// Port-level checks for the tree ancestor query engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tree_ancestor_query_engine_macros.svh"

module taq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [taq_pkg::ACTION_W-1:0]    in_action,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic                            out_is_ancestor,
  input logic [taq_pkg::STATUS_W-1:0]    out_status
);
  import taq_pkg::*;

  // A stalled result holds
  `TAQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_is_ancestor) && $stable(out_status), "stalled result changed")

  // A failed query never claims ancestry
  `TAQ_ASSERT_NOW(a_err_no_anc, out_valid && (out_status != STATUS_OK), !out_is_ancestor, "ancestor flag set on error status")

  // Clearing pass follows reset
  `TAQ_ASSERT_NOW(a_reset_clear, $past(!rst_n), in_stall, "input open right after reset")

  // Begin starts the clearing pass
  `TAQ_ASSERT_NEXT(a_begin_clear, in_valid && !in_stall && (in_action == ACT_BEGIN), in_stall, "input open after begin")

  // A query is worked on before the next transfer
  `TAQ_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (in_action == ACT_QUERY), in_stall, "input open after query")

endmodule

bind tree_ancestor_query_engine taq_checker u_taq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_action       (in_action),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_is_ancestor (out_is_ancestor),
  .out_status      (out_status)
);

`default_nettype wire
